/* rtl/fcs_pkg.sv */
// Package for the flash command sequencer: command words, status masks,
// operation, phase and result codes, and the result record with its builders.
// Depends on nothing; every other file imports it.
package fcs_pkg;

	localparam int ADDR_W = 24;
	localparam int DATA_W = 32;
	localparam int OP_W = 3;
	localparam int KIND_W = 2;
	localparam int OUTCOME_W = 2;
	localparam int LOCK_W = 2;

	localparam int ADDR_BITS_DEFAULT = 24;

	// Results one request can cause at most
	localparam int RES_DEPTH = 6;
	localparam int CNT_W = 3;

	// Command words, same byte in both 16-bit halves
	localparam logic [DATA_W-1:0] CMD_READ_ARRAY   = 32'h00FF_00FF;
	localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 32'h0020_0020;
	localparam logic [DATA_W-1:0] CMD_ERASE_OK     = 32'h00D0_00D0;
	localparam logic [DATA_W-1:0] CMD_PGM_SETUP    = 32'h0040_0040;
	localparam logic [DATA_W-1:0] CMD_STATUS_READ  = 32'h0070_0070;
	localparam logic [DATA_W-1:0] CMD_STATUS_CLEAR = 32'h0050_0050;
	localparam logic [DATA_W-1:0] CMD_CFG_SETUP    = 32'h0060_0060;
	localparam logic [DATA_W-1:0] CMD_LOCK         = 32'h0001_0001;
	localparam logic [DATA_W-1:0] CMD_UNLOCK       = 32'h00D0_00D0;
	localparam logic [DATA_W-1:0] CMD_READ_CONFIG  = 32'h0090_0090;

	// Status bits of both chips
	localparam logic [DATA_W-1:0] ST_READY     = 32'h0080_0080;
	localparam logic [DATA_W-1:0] ST_ERASE_ERR = 32'h0020_0020;
	localparam logic [DATA_W-1:0] ST_PGM_ERR   = 32'h0010_0010;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd0;
	localparam logic [OP_W-1:0] OP_PGM    = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCK   = 3'd2;
	localparam logic [OP_W-1:0] OP_UNLOCK = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;
	localparam logic [OP_W-1:0] OP_DATA   = 3'd5;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

	// Completion outcomes
	localparam logic [OUTCOME_W-1:0] OUT_OK        = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_ERASE_ERR = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_PGM_ERR   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ERASE,
		PH_PGM,
		PH_VERIFY,
		PH_LOCK,
		PH_UNLOCK,
		PH_QUERY
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [ADDR_W-1:0]    bus_address;
		logic [DATA_W-1:0]    bus_data;
		logic [OUTCOME_W-1:0] outcome;
		logic [LOCK_W-1:0]    lock_low;
		logic [LOCK_W-1:0]    lock_high;
	} result_t;

	function automatic result_t mk_wr(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		result_t r;
		r = '0;
		r.kind = KIND_WRITE;
		r.bus_address = addr;
		r.bus_data = data;
		return r;
	endfunction

	function automatic result_t mk_rd(logic [ADDR_W-1:0] addr);
		result_t r;
		r = '0;
		r.kind = KIND_READ;
		r.bus_address = addr;
		return r;
	endfunction

	function automatic result_t mk_done(logic [ADDR_W-1:0] addr, logic [OUTCOME_W-1:0] oc,
			logic [LOCK_W-1:0] lo, logic [LOCK_W-1:0] hi);
		result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.bus_address = addr;
		r.outcome = oc;
		r.lock_low = lo;
		r.lock_high = hi;
		return r;
	endfunction

endpackage

/* rtl/fcs_if.sv */
// Channel interfaces of the flash command sequencer: request/read-data items
// in, bus access and completion items out. Depends on fcs_pkg.

interface fcs_req_if;
	import fcs_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [ADDR_W-1:0]   address;
	logic [DATA_W-1:0]   write_data;
	logic [DATA_W-1:0]   read_data;

	modport source (output valid, operation, address, write_data, read_data, input ready);
	modport sink (input valid, operation, address, write_data, read_data, output ready);
endinterface

interface fcs_res_if;
	import fcs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [ADDR_W-1:0]    bus_address;
	logic [DATA_W-1:0]    bus_data;
	logic [OUTCOME_W-1:0] outcome;
	logic [LOCK_W-1:0]    lock_low;
	logic [LOCK_W-1:0]    lock_high;
	logic                 last;

	modport source (output valid, kind, bus_address, bus_data, outcome, lock_low, lock_high,
		last, input ready);
	modport sink (input valid, kind, bus_address, bus_data, outcome, lock_low, lock_high,
		last, output ready);
endinterface

/* rtl/flash_command_sequencer_top.sv */
// Flash command sequencer top level: input register, command decode and
// result shift buffer. Depends on fcs_pkg and the interfaces in fcs_if.sv.
//
//   channel  dir  item
//   req      in   request (erase/program/lock/unlock/query) or flash read data
//   res      out  bus write, bus read request or completion; last marks the end
//
// An accepted item is held in the input register until the buffer can take
// it; then its results (zero to six) load into a shift buffer and leave one
// per cycle while the output is ready. The next item is accepted while the
// buffer still drains and loads as the final result is taken. arst_n clears
// the phase, saved address and word and all valid state. A stalled output
// holds the buffer and, once the input register is full, drops ready on the
// input.
module flash_command_sequencer_top #(
	parameter int ADDR_BITS = fcs_pkg::ADDR_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	fcs_req_if.sink req,
	fcs_res_if.source res
);
	import fcs_pkg::*;

	// Address wrap mask: ADDR_BITS then the field width
	localparam logic [63:0] MaskWide = (64'd1 << ADDR_BITS) - 64'd1;
	localparam logic [ADDR_W-1:0] AddrMask = MaskWide[ADDR_W-1:0];

	// Input register
	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [DATA_W-1:0]   wdata_s1;
	logic [DATA_W-1:0]   rdata_s1;

	// Sequencer state
	phase_t              phase_q, phase_d;
	logic [ADDR_W-1:0]   saddr_q, saddr_d;
	logic [DATA_W-1:0]   sword_q, sword_d;

	// Result shift buffer, head at entry 0
	result_t             res_q [RES_DEPTH];
	logic [CNT_W-1:0]    cnt_q;

	result_t             res_d [RES_DEPTH];
	logic [CNT_W-1:0]    n_d;
	logic                take;
	logic                load;
	logic [ADDR_W-1:0]   a_new;
	logic [ADDR_W:0]     q_sum;
	logic [ADDR_W-1:0]   q_addr;

	assign take = res.valid && res.ready;
	// Load the decoded item when the buffer is empty or emits its final result now
	assign load = valid_s1 && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && take));
	assign req.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1 <= req.operation;
			addr_s1 <= req.address;
			wdata_s1 <= req.write_data;
			rdata_s1 <= req.read_data;
		end
	end

	assign a_new = addr_s1 & AddrMask;
	// Query reads the lock word two words up, wrapping
	assign q_sum = {1'b0, a_new} + (ADDR_W+1)'(2);
	assign q_addr = q_sum[ADDR_W-1:0] & AddrMask;

	// Decode one item into its result list and the next state
	always_comb begin
		phase_d = phase_q;
		saddr_d = saddr_q;
		sword_d = sword_q;
		n_d = '0;
		for (int i = 0; i < RES_DEPTH; i++) begin
			res_d[i] = '0;
		end

		if (op_s1 == OP_DATA) begin
			case (phase_q)
				PH_ERASE, PH_PGM: begin
					n_d = CNT_W'(2);
					if ((~rdata_s1 & ST_READY) != '0) begin
						// Busy in at least one chip: poll again
						res_d[0] = mk_wr(saddr_q, CMD_STATUS_READ);
						res_d[1] = mk_rd(saddr_q);
					end else begin
						res_d[0] = mk_wr(saddr_q, CMD_READ_ARRAY);
						if (phase_q == PH_ERASE) begin
							res_d[1] = mk_done(saddr_q,
								((rdata_s1 & ST_ERASE_ERR) != '0) ? OUT_ERASE_ERR : OUT_OK,
								'0, '0);
							phase_d = PH_IDLE;
						end else if ((rdata_s1 & ST_PGM_ERR) != '0) begin
							res_d[1] = mk_done(saddr_q, OUT_PGM_ERR, '0, '0);
							phase_d = PH_IDLE;
						end else begin
							// Read back the word for verify
							res_d[1] = mk_rd(saddr_q);
							phase_d = PH_VERIFY;
						end
					end
				end
				PH_VERIFY: begin
					n_d = CNT_W'(1);
					res_d[0] = mk_done(saddr_q, (rdata_s1 == sword_q) ? OUT_OK : OUT_PGM_ERR,
						'0, '0);
					phase_d = PH_IDLE;
				end
				PH_LOCK, PH_UNLOCK: begin
					n_d = CNT_W'(2);
					res_d[0] = mk_wr(saddr_q, CMD_READ_ARRAY);
					res_d[1] = mk_done(saddr_q,
						((rdata_s1 & ST_PGM_ERR) != '0) ? OUT_PGM_ERR : OUT_OK, '0, '0);
					phase_d = PH_IDLE;
				end
				PH_QUERY: begin
					n_d = CNT_W'(2);
					res_d[0] = mk_wr(saddr_q, CMD_READ_ARRAY);
					res_d[1] = mk_done(saddr_q, OUT_OK, rdata_s1[1:0], rdata_s1[17:16]);
					phase_d = PH_IDLE;
				end
				default: begin
					// No operation pending: drop the data
				end
			endcase
		end else if ((op_s1 <= OP_QUERY) && (phase_q == PH_IDLE)) begin
			saddr_d = a_new;
			case (op_s1)
				OP_ERASE: begin
					res_d[0] = mk_wr(a_new, CMD_STATUS_CLEAR);
					res_d[1] = mk_wr(a_new, CMD_ERASE_SETUP);
					res_d[2] = mk_wr(a_new, CMD_ERASE_OK);
					res_d[3] = mk_wr(a_new, CMD_STATUS_READ);
					res_d[4] = mk_rd(a_new);
					n_d = CNT_W'(5);
					phase_d = PH_ERASE;
				end
				OP_PGM: begin
					sword_d = wdata_s1;
					res_d[0] = mk_wr(a_new, CMD_STATUS_CLEAR);
					res_d[1] = mk_wr(a_new, CMD_PGM_SETUP);
					res_d[2] = mk_wr(a_new, wdata_s1);
					res_d[3] = mk_wr(a_new, CMD_STATUS_READ);
					res_d[4] = mk_rd(a_new);
					n_d = CNT_W'(5);
					phase_d = PH_PGM;
				end
				OP_LOCK: begin
					res_d[0] = mk_wr(a_new, CMD_STATUS_CLEAR);
					res_d[1] = mk_wr(a_new, CMD_CFG_SETUP);
					res_d[2] = mk_wr(a_new, CMD_LOCK);
					res_d[3] = mk_wr(a_new, CMD_READ_ARRAY);
					res_d[4] = mk_wr(a_new, CMD_STATUS_READ);
					res_d[5] = mk_rd(a_new);
					n_d = CNT_W'(6);
					phase_d = PH_LOCK;
				end
				OP_UNLOCK: begin
					res_d[0] = mk_wr(a_new, CMD_STATUS_CLEAR);
					res_d[1] = mk_wr(a_new, CMD_CFG_SETUP);
					res_d[2] = mk_wr(a_new, CMD_UNLOCK);
					res_d[3] = mk_wr(a_new, CMD_STATUS_READ);
					res_d[4] = mk_rd(a_new);
					n_d = CNT_W'(5);
					phase_d = PH_UNLOCK;
				end
				default: begin
					// Query lock
					res_d[0] = mk_wr(a_new, CMD_READ_CONFIG);
					res_d[1] = mk_rd(q_addr);
					n_d = CNT_W'(2);
					phase_d = PH_QUERY;
				end
			endcase
		end
	end

	// Advance the sequencer state as each item loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			saddr_q <= '0;
			sword_q <= '0;
		end else if (load) begin
			phase_q <= phase_d;
			saddr_q <= saddr_d;
			sword_q <= sword_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_d;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end else if (take) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign res.valid = (cnt_q != '0);
	assign res.last = (cnt_q == CNT_W'(1));
	assign res.kind = res_q[0].kind;
	assign res.bus_address = res_q[0].bus_address;
	assign res.bus_data = res_q[0].bus_data;
	assign res.outcome = res_q[0].outcome;
	assign res.lock_low = res_q[0].lock_low;
	assign res.lock_high = res_q[0].lock_high;

endmodule

/* tb/tb.sv */
// Self-checking bench for flash_command_sequencer_top: a table of directed items, then
// random request/status sequences, each result checked against an in-bench predictor.
// Depends on fcs_pkg, the channel interfaces in fcs_if.sv and the top level.
module tb;
	import fcs_pkg::*;

	// Operation codes the block must ignore
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	// Halves of a status word, one per chip
	localparam logic [DATA_W-1:0] LOW_CHIP  = 32'h0000_FFFF;
	localparam logic [DATA_W-1:0] HIGH_CHIP = 32'hFFFF_0000;

	localparam int DIR_N = 26;
	localparam int RAND_USEFUL = 160;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AT = 80;

	typedef struct {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] read_data;
	} req_item_t;

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic [ADDR_W-1:0]    bus_address;
		logic [DATA_W-1:0]    bus_data;
		logic [OUTCOME_W-1:0] outcome;
		logic [LOCK_W-1:0]    lock_low;
		logic [LOCK_W-1:0]    lock_high;
		logic                 last;
	} bus_item_t;

	// One directed row; typed rows end in a completion whose fields are given here
	typedef struct {
		logic [OP_W-1:0]      operation;
		logic [ADDR_W-1:0]    address;
		logic [DATA_W-1:0]    write_data;
		logic [DATA_W-1:0]    read_data;
		bit                   typed;
		logic [OUTCOME_W-1:0] outcome;
		logic [LOCK_W-1:0]    lock_low;
		logic [LOCK_W-1:0]    lock_high;
	} dir_row_t;

	logic clk;
	logic arst_n;
	int fail_count;

	fcs_req_if req();
	fcs_res_if res();

	flash_command_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res)
	);

	// Predictor state: pending operation, its address and the word being programmed
	phase_t seq_phase;
	logic [ADDR_W-1:0] seq_addr;
	logic [DATA_W-1:0] seq_word;
	bus_item_t access_q[$];

	function automatic void push_access(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic [OUTCOME_W-1:0] oc, logic [LOCK_W-1:0] lo,
			logic [LOCK_W-1:0] hi);
		bus_item_t b;
		b.kind = k;
		b.bus_address = a;
		b.bus_data = d;
		b.outcome = oc;
		b.lock_low = lo;
		b.lock_high = hi;
		b.last = 1'b0;
		access_q.push_back(b);
	endfunction

	function automatic void cmd_write(logic [DATA_W-1:0] d);
		push_access(KIND_WRITE, seq_addr, d, OUT_OK, '0, '0);
	endfunction

	function automatic void read_req(logic [ADDR_W-1:0] a);
		push_access(KIND_READ, a, '0, OUT_OK, '0, '0);
	endfunction

	function automatic void complete(logic [OUTCOME_W-1:0] oc, logic [LOCK_W-1:0] lo,
			logic [LOCK_W-1:0] hi);
		push_access(KIND_DONE, seq_addr, '0, oc, lo, hi);
		seq_phase = PH_IDLE;
	endfunction

	// Advance the sequencer by one accepted item; queue the bus accesses and
	// completion it causes and return how many
	function automatic int sequence_step(req_item_t it);
		int n0;
		logic [DATA_W-1:0] st;
		n0 = access_q.size();
		st = it.read_data;
		if (it.operation == OP_DATA) begin
			case (seq_phase)
				PH_ERASE, PH_PGM: begin
					if ((st & ST_READY) != ST_READY) begin
						cmd_write(CMD_STATUS_READ);
						read_req(seq_addr);
					end else begin
						cmd_write(CMD_READ_ARRAY);
						if (seq_phase == PH_ERASE)
							complete((st & ST_ERASE_ERR) != '0 ? OUT_ERASE_ERR : OUT_OK, '0, '0);
						else if ((st & ST_PGM_ERR) != '0)
							complete(OUT_PGM_ERR, '0, '0);
						else begin
							read_req(seq_addr);
							seq_phase = PH_VERIFY;
						end
					end
				end
				PH_VERIFY: complete(st == seq_word ? OUT_OK : OUT_PGM_ERR, '0, '0);
				PH_LOCK, PH_UNLOCK: begin
					cmd_write(CMD_READ_ARRAY);
					complete((st & ST_PGM_ERR) != '0 ? OUT_PGM_ERR : OUT_OK, '0, '0);
				end
				PH_QUERY: begin
					cmd_write(CMD_READ_ARRAY);
					complete(OUT_OK, st[1:0], st[17:16]);
				end
				default: ;
			endcase
		end else if (it.operation <= OP_QUERY && seq_phase == PH_IDLE) begin
			// ADDR_BITS equals the field width here, so the address passes unchanged
			seq_addr = it.address;
			case (it.operation)
				OP_ERASE: begin
					cmd_write(CMD_STATUS_CLEAR);
					cmd_write(CMD_ERASE_SETUP);
					cmd_write(CMD_ERASE_OK);
					seq_phase = PH_ERASE;
				end
				OP_PGM: begin
					seq_word = it.write_data;
					cmd_write(CMD_STATUS_CLEAR);
					cmd_write(CMD_PGM_SETUP);
					cmd_write(seq_word);
					seq_phase = PH_PGM;
				end
				OP_LOCK: begin
					cmd_write(CMD_STATUS_CLEAR);
					cmd_write(CMD_CFG_SETUP);
					cmd_write(CMD_LOCK);
					cmd_write(CMD_READ_ARRAY);
					seq_phase = PH_LOCK;
				end
				OP_UNLOCK: begin
					cmd_write(CMD_STATUS_CLEAR);
					cmd_write(CMD_CFG_SETUP);
					cmd_write(CMD_UNLOCK);
					seq_phase = PH_UNLOCK;
				end
				default: begin
					// Lock bits sit two words up; the sum wraps at the address width
					cmd_write(CMD_READ_CONFIG);
					read_req(seq_addr + ADDR_W'(2));
					seq_phase = PH_QUERY;
				end
			endcase
			if (it.operation != OP_QUERY) begin
				cmd_write(CMD_STATUS_READ);
				read_req(seq_addr);
			end
		end
		if (access_q.size() > n0)
			access_q[access_q.size() - 1].last = 1'b1;
		return access_q.size() - n0;
	endfunction

	// Draw the next random item from the pending phase: mostly what a flash
	// would send back, with some requests while busy and reserved codes mixed in
	function automatic req_item_t draw_item();
		req_item_t it;
		int pick;
		it.operation = OP_DATA;
		it.address = ADDR_W'($urandom);
		it.write_data = $urandom;
		it.read_data = $urandom;
		pick = $urandom_range(0, 99);
		if (seq_phase == PH_IDLE) begin
			if (pick < 85) begin
				it.operation = OP_W'($urandom_range(0, 4));
				if (pick < 8)
					it.address = '0;
				else if (pick < 16)
					it.address = '1;
			end else if (pick < 92)
				it.operation = OP_DATA;
			else
				it.operation = (pick % 2 == 0) ? OP_RSVD6 : OP_RSVD7;
		end else if (pick >= 90) begin
			it.operation = OP_W'($urandom_range(0, 7));
		end else begin
			case (seq_phase)
				PH_ERASE, PH_PGM: begin
					if (pick < 35) begin
						case ($urandom_range(0, 2))
							0: it.read_data &= ~(ST_READY & LOW_CHIP);
							1: it.read_data &= ~(ST_READY & HIGH_CHIP);
							default: it.read_data &= ~ST_READY;
						endcase
					end else begin
						it.read_data |= ST_READY;
						if ($urandom_range(0, 3) != 0)
							it.read_data &= ~(seq_phase == PH_ERASE ? ST_ERASE_ERR : ST_PGM_ERR);
					end
				end
				PH_VERIFY: if (pick < 50) it.read_data = seq_word;
				default: ;
			endcase
		end
		return it;
	endfunction

	// Sender gap: runs of back-to-back items, otherwise random idle gaps
	function automatic int sender_gap(int idx);
		return (idx % 64 < 16) ? 0 : $urandom_range(0, 7);
	endfunction

	// Offer one item after the gap and hold it until the block takes it
	task automatic offer(req_item_t it, int gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= it.operation;
		req.address <= it.address;
		req.write_data <= it.write_data;
		req.read_data <= it.read_data;
		do @(posedge clk); while (!req.ready);
	endtask

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: a random stall before each item, with runs of no stall and one
	// long hold-off that backs the block up into its input
	initial begin : drain
		int taken;
		int stall;
		bus_item_t want;
		taken = 0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT)
				stall = LONG_HOLD;
			else if (taken % 128 < 32)
				stall = 0;
			else
				stall = $urandom_range(0, 7);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			taken++;
			if (access_q.size() == 0) begin
				$display("%0t: expected no result, actual kind %h address %h data %h",
					$time, res.kind, res.bus_address, res.bus_data);
				fail_count++;
			end else begin
				want = access_q.pop_front();
				check_field("kind", want.kind, res.kind);
				check_field("bus_address", want.bus_address, res.bus_address);
				check_field("bus_data", want.bus_data, res.bus_data);
				check_field("outcome", want.outcome, res.outcome);
				check_field("lock_low", want.lock_low, res.lock_low);
				check_field("lock_high", want.lock_high, res.lock_high);
				check_field("last", want.last, res.last);
			end
		end
	end

	// Stimulus: reset, the directed table, then random sequences
	initial begin : stim
		dir_row_t dir_rows [DIR_N];
		req_item_t it;
		int useful;
		int idx;
		int n;

		fail_count = 0;
		seq_phase = PH_IDLE;
		seq_addr = '0;
		seq_word = '0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.operation <= OP_ERASE;
		req.address <= '0;
		req.write_data <= '0;
		req.read_data <= '0;

		dir_rows = '{
			// data while idle, then reserved codes: all ignored
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_RSVD6,  24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_RSVD7,  24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			// erase at zero; each chip alone ready still polls; request while busy dropped
			'{OP_ERASE,  24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0080_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0000_0080, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_PGM,    24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h00A0_00A0, 1'b1, OUT_ERASE_ERR,
				2'd0, 2'd0},
			// erase at the top address, clean status
			'{OP_ERASE,  24'hFFFFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'hFFDF_FFDF, 1'b1, OUT_OK, 2'd0, 2'd0},
			// program with error bit reported
			'{OP_PGM,    24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0090_0090, 1'b1, OUT_PGM_ERR,
				2'd0, 2'd0},
			// program, verify matches
			'{OP_PGM,    24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0080_0080, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0000_0000, 1'b1, OUT_OK, 2'd0, 2'd0},
			// program, verify mismatches
			'{OP_PGM,    24'h123456, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'hFFEF_FFEF, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, OUT_PGM_ERR,
				2'd0, 2'd0},
			// lock with error in one chip only, unlock clean
			'{OP_LOCK,   24'h000010, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0000_0010, 1'b1, OUT_PGM_ERR,
				2'd0, 2'd0},
			'{OP_UNLOCK, 24'h800000, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'hFFEF_FFEF, 1'b1, OUT_OK, 2'd0, 2'd0},
			// queries near the top so the lock-bit read wraps
			'{OP_QUERY,  24'hFFFFFE, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, OUT_OK, 2'd3, 2'd3},
			'{OP_QUERY,  24'hFFFFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, OUT_OK, 2'd0, 2'd0},
			'{OP_DATA,   24'h000000, 32'h0000_0000, 32'h0002_0001, 1'b1, OUT_OK, 2'd1, 2'd2}
		};

		// Hold reset, then release it for good
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		for (int i = 0; i < DIR_N; i++) begin
			it.operation = dir_rows[i].operation;
			it.address = dir_rows[i].address;
			it.write_data = dir_rows[i].write_data;
			it.read_data = dir_rows[i].read_data;
			offer(it, sender_gap(idx));
			idx++;
			n = sequence_step(it);
			// Typed rows: the completion fields come straight from the table
			if (dir_rows[i].typed && n > 0) begin
				access_q[access_q.size() - 1].outcome = dir_rows[i].outcome;
				access_q[access_q.size() - 1].lock_low = dir_rows[i].lock_low;
				access_q[access_q.size() - 1].lock_high = dir_rows[i].lock_high;
			end
		end

		// Random part; ignored items do not advance the count
		useful = 0;
		while (useful < RAND_USEFUL) begin
			it = draw_item();
			offer(it, sender_gap(idx));
			idx++;
			if (sequence_step(it) > 0)
				useful++;
		end
		req.valid <= 1'b0;

		// Drain what is still owed, then watch a little longer for strays
		while (access_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
